### hdl/hbridge_speed_to_pwm_with_boost_assert.svh
// Assertion macros used by the top RTL file of the H-bridge PWM block.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef HBRIDGE_SPEED_TO_PWM_WITH_BOOST_ASSERT_SVH
`define HBRIDGE_SPEED_TO_PWM_WITH_BOOST_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HBPWM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HBPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/hbpwm_pkg.sv
package hbpwm_pkg;

    typedef enum logic [1:0] {
        KIND_SET_SPEED = 2'd0,
        KIND_CONTROL   = 2'd1,
        KIND_COAST     = 2'd2,
        KIND_BRAKE     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        DIR_STOP = 2'b00,
        DIR_FWD  = 2'b01,
        DIR_REV  = 2'b11
    } t_dir;

    localparam int OUT_W        = 10;
    localparam int CFG_VAL_W    = 10;
    localparam int TIME_W       = 16;
    localparam int NOW_W        = 32;
    localparam int SPEED_W      = 8;
    localparam int MAG_W        = 7;
    localparam int SPEED_FULL   = 100;
    localparam int ADDR_W       = 5;
    localparam int APB_W        = 32;
    localparam int IN_TDATA_W   = 40;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 24;
    localparam int QDEPTH       = 2;
    localparam int CNT_W        = 2;

    localparam logic signed [SPEED_W-1:0] SPEED_MAX = 8'sd100;
    localparam logic signed [SPEED_W-1:0] SPEED_MIN = -8'sd100;

    localparam logic [CFG_VAL_W-1:0] CFG_DUTY_RST = 10'd1023;

    localparam logic [2:0] REG_MIN_FWD    = 3'd0;
    localparam logic [2:0] REG_MIN_REV    = 3'd1;
    localparam logic [2:0] REG_MAX        = 3'd2;
    localparam logic [2:0] REG_BOOST_FWD  = 3'd3;
    localparam logic [2:0] REG_BOOST_REV  = 3'd4;
    localparam logic [2:0] REG_BOOST_TIME = 3'd5;
    localparam logic [2:0] REG_BRAKE      = 3'd6;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        t_dir              dir;
        logic [NOW_W-1:0]  now_ms;
    } t_item;

    typedef struct packed {
        logic [OUT_W-1:0] fwd;
        logic [OUT_W-1:0] rev;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [1:0] num;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

### hdl/hbpwm_cfg.sv
module hbpwm_cfg
    import hbpwm_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic [ADDR_W-1:0]     i_paddr,
    input  logic [APB_W-1:0]      i_pwdata,
    output logic [APB_W-1:0]      o_prdata,
    output logic [DUTY_BITS-1:0]  o_min_fwd,
    output logic [DUTY_BITS-1:0]  o_min_rev,
    output logic [DUTY_BITS-1:0]  o_max,
    output logic [DUTY_BITS-1:0]  o_boost_fwd,
    output logic [DUTY_BITS-1:0]  o_boost_rev,
    output logic [TIME_W-1:0]     o_boost_time,
    output logic [DUTY_BITS-1:0]  o_brake
);

    logic [DUTY_BITS-1:0] r_min_fwd;
    logic [DUTY_BITS-1:0] r_min_rev;
    logic [DUTY_BITS-1:0] r_max;
    logic [DUTY_BITS-1:0] r_boost_fwd;
    logic [DUTY_BITS-1:0] r_boost_rev;
    logic [TIME_W-1:0]    r_boost_time;
    logic [DUTY_BITS-1:0] r_brake;
    logic                 w_wr;
    logic [2:0]           w_idx;
    logic [DUTY_BITS-1:0] w_wdat;

    assign w_wr   = i_psel & i_penable & i_pwrite;
    assign w_idx  = i_paddr[ADDR_W-1:2];
    assign w_wdat = DUTY_BITS'(i_pwdata[CFG_VAL_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_fwd    <= '0;
            r_min_rev    <= '0;
            r_max        <= DUTY_BITS'(CFG_DUTY_RST);
            r_boost_fwd  <= '0;
            r_boost_rev  <= '0;
            r_boost_time <= '0;
            r_brake      <= DUTY_BITS'(CFG_DUTY_RST);
        end else if (w_wr) begin
            unique case (w_idx)
                REG_MIN_FWD:    r_min_fwd    <= w_wdat;
                REG_MIN_REV:    r_min_rev    <= w_wdat;
                REG_MAX:        r_max        <= w_wdat;
                REG_BOOST_FWD:  r_boost_fwd  <= w_wdat;
                REG_BOOST_REV:  r_boost_rev  <= w_wdat;
                REG_BOOST_TIME: r_boost_time <= i_pwdata[TIME_W-1:0];
                REG_BRAKE:      r_brake      <= w_wdat;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_MIN_FWD:    o_prdata = APB_W'(r_min_fwd);
            REG_MIN_REV:    o_prdata = APB_W'(r_min_rev);
            REG_MAX:        o_prdata = APB_W'(r_max);
            REG_BOOST_FWD:  o_prdata = APB_W'(r_boost_fwd);
            REG_BOOST_REV:  o_prdata = APB_W'(r_boost_rev);
            REG_BOOST_TIME: o_prdata = APB_W'(r_boost_time);
            REG_BRAKE:      o_prdata = APB_W'(r_brake);
            default:        o_prdata = '0;
        endcase
    end

    assign o_min_fwd    = r_min_fwd;
    assign o_min_rev    = r_min_rev;
    assign o_max        = r_max;
    assign o_boost_fwd  = r_boost_fwd;
    assign o_boost_rev  = r_boost_rev;
    assign o_boost_time = r_boost_time;
    assign o_brake      = r_brake;

endmodule

### hdl/hbpwm_map.sv
module hbpwm_map
    import hbpwm_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  t_kind                       i_kind,
    input  logic signed [SPEED_W-1:0]   i_speed,
    input  logic [NOW_W-1:0]            i_now,
    input  logic [DUTY_BITS-1:0]        i_min_fwd,
    input  logic [DUTY_BITS-1:0]        i_min_rev,
    input  logic [DUTY_BITS-1:0]        i_max,
    output t_item                       o_item,
    output logic [DUTY_BITS-1:0]        o_duty
);

    localparam int PM_W   = MAG_W + DUTY_BITS;
    localparam int SH     = PM_W + 7;
    localparam int RW     = SH - 5;
    localparam int PROD_W = PM_W + RW;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SH) + 64'(SPEED_FULL) - 64'd1) / 64'(SPEED_FULL);
    localparam logic [RW-1:0] RECIP = RECIP_WIDE[RW-1:0];

    logic signed [SPEED_W-1:0] r_setpoint;
    logic signed [SPEED_W-1:0] n_setpoint;
    t_item                     r_s1;
    logic [PM_W-1:0]           r_pm;
    logic                      r_neg;
    logic [DUTY_BITS-1:0]      r_lo;
    t_item                     r_s2;
    logic [DUTY_BITS-1:0]      r_duty;

    logic                      w_acc;
    logic signed [SPEED_W-1:0] w_clamp;
    t_dir                      w_dir;
    logic [SPEED_W-1:0]        w_abs;
    logic [MAG_W-1:0]          w_mag;
    logic [DUTY_BITS-1:0]      w_lo;
    logic                      w_neg;
    logic [DUTY_BITS-1:0]      w_adiff;
    logic [PM_W-1:0]           w_pm;
    logic [PROD_W-1:0]         w_prod;
    logic [DUTY_BITS-1:0]      w_q;
    logic [DUTY_BITS-1:0]      w_duty;

    assign w_acc = i_valid & i_en;

    always_comb begin
        if (i_speed > SPEED_MAX) begin
            w_clamp = SPEED_MAX;
        end else if (i_speed < SPEED_MIN) begin
            w_clamp = SPEED_MIN;
        end else begin
            w_clamp = i_speed;
        end
        unique case (i_kind)
            KIND_SET_SPEED: n_setpoint = w_clamp;
            KIND_CONTROL:   n_setpoint = r_setpoint;
            KIND_COAST:     n_setpoint = '0;
            KIND_BRAKE:     n_setpoint = '0;
        endcase
    end

    always_comb begin
        if (r_setpoint == '0) begin
            w_dir = DIR_STOP;
        end else if (r_setpoint[SPEED_W-1]) begin
            w_dir = DIR_REV;
        end else begin
            w_dir = DIR_FWD;
        end
        w_abs   = r_setpoint[SPEED_W-1] ? (~r_setpoint + 8'd1) : r_setpoint;
        w_mag   = w_abs[MAG_W-1:0];
        w_lo    = (w_dir == DIR_FWD) ? i_min_fwd : i_min_rev;
        w_neg   = i_max < w_lo;
        w_adiff = w_neg ? (w_lo - i_max) : (i_max - w_lo);
        w_pm    = PM_W'(w_mag) * PM_W'(w_adiff);
    end

    assign w_prod = PROD_W'(r_pm) * PROD_W'(RECIP);
    assign w_q    = w_prod[SH +: DUTY_BITS];
    assign w_duty = (r_s1.dir == DIR_STOP) ? '0 : (r_neg ? (r_lo - w_q) : (r_lo + w_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_s1       <= '0;
            r_s2       <= '0;
        end else if (i_en) begin
            if (w_acc) begin
                r_setpoint <= n_setpoint;
            end
            r_s1 <= '{valid: i_valid, kind: i_kind, dir: w_dir, now_ms: i_now};
            r_s2 <= r_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pm   <= w_pm;
            r_neg  <= w_neg;
            r_lo   <= w_lo;
            r_duty <= w_duty;
        end
    end

    assign o_item = r_s2;
    assign o_duty = r_duty;

endmodule

### hdl/hbpwm_ctrl.sv
module hbpwm_ctrl
    import hbpwm_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  t_item                 i_item,
    input  logic [DUTY_BITS-1:0]  i_duty,
    input  logic [DUTY_BITS-1:0]  i_boost_fwd,
    input  logic [DUTY_BITS-1:0]  i_boost_rev,
    input  logic [TIME_W-1:0]     i_boost_time,
    input  logic [DUTY_BITS-1:0]  i_brake,
    output t_push                 o_push
);

    t_dir                 r_adir;
    t_dir                 n_adir;
    logic [DUTY_BITS-1:0] r_aduty;
    logic [DUTY_BITS-1:0] n_aduty;
    logic [NOW_W-1:0]     r_deadline;
    logic [NOW_W-1:0]     n_deadline;
    logic [DUTY_BITS-1:0] w_boost;
    logic [NOW_W-1:0]     w_dl;
    logic [DUTY_BITS-1:0] w_app;
    t_push                w_push;

    assign w_boost = (i_item.dir == DIR_FWD) ? i_boost_fwd : i_boost_rev;

    always_comb begin
        n_adir     = r_adir;
        n_aduty    = r_aduty;
        n_deadline = r_deadline;
        w_dl       = r_deadline;
        w_app      = i_duty;
        w_push     = '0;
        unique case (i_item.kind)
            KIND_SET_SPEED: ;
            KIND_CONTROL: begin
                if (i_item.dir != r_adir) begin
                    if (i_item.dir == DIR_STOP || i_duty >= w_boost) begin
                        w_dl = '0;
                    end else begin
                        w_dl = i_item.now_ms + NOW_W'(i_boost_time);
                    end
                end
                if (w_dl != '0 && i_item.dir != DIR_STOP) begin
                    if (i_item.now_ms < w_dl) begin
                        w_app = w_boost;
                    end else begin
                        w_dl = '0;
                    end
                end
                n_deadline = w_dl;
                if (w_app != r_aduty || i_item.dir != r_adir) begin
                    n_aduty = w_app;
                    n_adir  = i_item.dir;
                    if (i_item.dir != DIR_STOP) begin
                        w_push.num        = 2'd1;
                        w_push.first.fwd  = (i_item.dir == DIR_FWD) ? OUT_W'(w_app) : '0;
                        w_push.first.rev  = (i_item.dir == DIR_REV) ? OUT_W'(w_app) : '0;
                        w_push.first.last = 1'b1;
                    end
                end
            end
            KIND_COAST: begin
                w_push.num        = 2'd1;
                w_push.first.last = 1'b1;
                n_adir            = DIR_STOP;
                n_aduty           = '0;
                n_deadline        = '0;
            end
            KIND_BRAKE: begin
                w_push.num         = 2'd2;
                w_push.first.fwd   = OUT_W'(i_brake);
                w_push.first.rev   = OUT_W'(i_brake);
                w_push.second.last = 1'b1;
                n_adir             = DIR_STOP;
                n_aduty            = '0;
                n_deadline         = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_adir     <= DIR_STOP;
            r_aduty    <= '0;
            r_deadline <= '0;
        end else if (i_en && i_item.valid) begin
            r_adir     <= n_adir;
            r_aduty    <= n_aduty;
            r_deadline <= n_deadline;
        end
    end

    assign o_push = w_push;

endmodule

### hdl/hbpwm_outq.sv
module hbpwm_outq
    import hbpwm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    input  t_push             i_push,
    input  logic              i_tready,
    output logic              o_en,
    output logic              o_tvalid,
    output t_result           o_result,
    output logic [CNT_W-1:0]  o_cnt
);

    t_result          r_q [QDEPTH];
    t_result          n_q [QDEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_pop;
    logic             w_room;
    logic             w_do_push;

    assign w_pop     = (r_cnt != '0) & i_tready;
    assign w_room    = ({1'b0, r_cnt} + {1'b0, i_push.num}) <= (CNT_W + 1)'(QDEPTH);
    assign w_do_push = i_push_valid & w_room;

    always_comb begin
        n_q   = r_q;
        n_cnt = r_cnt;
        if (w_pop) begin
            n_q[0] = r_q[1];
            n_cnt  = r_cnt - 1'b1;
        end
        if (w_do_push) begin
            unique case (i_push.num)
                2'd1: begin
                    n_q[n_cnt[0]] = i_push.first;
                    n_cnt         = n_cnt + 1'b1;
                end
                2'd2: begin
                    n_q[0] = i_push.first;
                    n_q[1] = i_push.second;
                    n_cnt  = CNT_W'(QDEPTH);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_en     = !i_push_valid || w_room;
    assign o_tvalid = r_cnt != '0;
    assign o_result = r_q[0];
    assign o_cnt    = r_cnt;

endmodule

### hdl/hbridge_speed_to_pwm_with_boost.sv
// H-bridge speed to PWM drive with start boost.
// Items enter on the s_axis stream: tuser carries the kind (set speed, control
// update, coast, brake), tdata the signed speed percent and the millisecond
// timestamp. Results leave on the m_axis stream as a forward and a reverse
// duty, with tlast set on the final result that an item causes.
// The APB port holds the duty floors, the maximum duty, the boost duties, the
// boost time and the brake duty; the user must write it only while the block
// is idle, and the block itself does not enforce this. One item is accepted
// every cycle while s_axis_tready is high, and results leave at up to one per
// cycle. A two-entry output queue behind the decision stage sets that rate: a
// brake needs both entries free, so it waits until the queue has drained. When
// the receiver stalls, the queue fills and s_axis_tready drops as soon as the
// item in the decision stage finds no room; it is driven from registers only,
// and no transfer is lost. Reset clears the setpoint, applied direction, duty
// and boost deadline, empties the pipeline and queue, and loads the registers
// with their defaults.
`include "hbridge_speed_to_pwm_with_boost_assert.svh"

module hbridge_speed_to_pwm_with_boost
    import hbpwm_pkg::*;
#(
    parameter int DUTY_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,   // speed_percent[7:0], now_ms[39:8]
    input  logic [IN_TUSER_W-1:0]   s_axis_tuser,   // kind[1:0]
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,   // forward_duty[9:0], reverse_duty[19:10]
    output logic                    m_axis_tlast,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [APB_W-1:0]        pwdata,
    output logic [APB_W-1:0]        prdata,
    output logic                    pready
);

    logic [DUTY_BITS-1:0] w_min_fwd;
    logic [DUTY_BITS-1:0] w_min_rev;
    logic [DUTY_BITS-1:0] w_max;
    logic [DUTY_BITS-1:0] w_boost_fwd;
    logic [DUTY_BITS-1:0] w_boost_rev;
    logic [TIME_W-1:0]    w_boost_time;
    logic [DUTY_BITS-1:0] w_brake;
    logic                 w_en;
    t_item                w_item;
    logic [DUTY_BITS-1:0] w_duty;
    t_push                w_push;
    t_result              w_res;
    logic [CNT_W-1:0]     w_cnt;

    assign pready = 1'b1;

    hbpwm_cfg #(
        .DUTY_BITS (DUTY_BITS)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_prdata     (prdata),
        .o_min_fwd    (w_min_fwd),
        .o_min_rev    (w_min_rev),
        .o_max        (w_max),
        .o_boost_fwd  (w_boost_fwd),
        .o_boost_rev  (w_boost_rev),
        .o_boost_time (w_boost_time),
        .o_brake      (w_brake)
    );

    hbpwm_map #(
        .DUTY_BITS (DUTY_BITS)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (s_axis_tvalid),
        .i_kind    (t_kind'(s_axis_tuser)),
        .i_speed   ($signed(s_axis_tdata[SPEED_W-1:0])),
        .i_now     (s_axis_tdata[SPEED_W +: NOW_W]),
        .i_min_fwd (w_min_fwd),
        .i_min_rev (w_min_rev),
        .i_max     (w_max),
        .o_item    (w_item),
        .o_duty    (w_duty)
    );

    hbpwm_ctrl #(
        .DUTY_BITS (DUTY_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_item       (w_item),
        .i_duty       (w_duty),
        .i_boost_fwd  (w_boost_fwd),
        .i_boost_rev  (w_boost_rev),
        .i_boost_time (w_boost_time),
        .i_brake      (w_brake),
        .o_push       (w_push)
    );

    hbpwm_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_item.valid),
        .i_push       (w_push),
        .i_tready     (m_axis_tready),
        .o_en         (w_en),
        .o_tvalid     (m_axis_tvalid),
        .o_result     (w_res),
        .o_cnt        (w_cnt)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tdata  = {{(OUT_TDATA_W - 2 * OUT_W){1'b0}}, w_res.rev, w_res.fwd};
    assign m_axis_tlast  = w_res.last;

    `HBPWM_ASSERT_SAME(a_queue_bound, 1'b1, w_cnt <= CNT_W'(QDEPTH), "output queue overfilled")
    `HBPWM_ASSERT_NEXT(a_brake_tail, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast && (w_res.fwd == '0) && (w_res.rev == '0), "brake not followed by coast result")
    `HBPWM_ASSERT_SAME(a_one_side, m_axis_tvalid && m_axis_tlast, (w_res.fwd == '0) || (w_res.rev == '0), "both bridge sides driven on a final result")

endmodule
